[src/mtc_pkg.sv]
package mtc_pkg;

    localparam int WORD_W  = 32;
    localparam int TIME_W  = 64;
    localparam int DIV_W   = 16;
    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 3;

    // function codes; code three is a no-op
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    // word register map
    localparam logic [INDEX_W-1:0] REG_CTRL    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_TIME_LO = 3'd2;
    localparam logic [INDEX_W-1:0] REG_TIME_HI = 3'd3;
    localparam logic [INDEX_W-1:0] REG_CMP_LO  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_CMP_HI  = 3'd5;

    localparam int CTRL_ENABLE_BIT = 0;

    localparam logic [DIV_W-1:0]  TICK_DIVIDE_RESET = 16'd50;
    localparam logic [TIME_W-1:0] CMP_RESET         = {TIME_W{1'b1}};

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] reg_index;
        logic [WORD_W-1:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              timer_irq;
    } out_item_t;

endpackage

[src/mtc_core.sv]
module mtc_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              exec_en,
    input  mtc_pkg::in_item_t                 item,
    input  logic                              cfg_wr_en,
    input  logic [mtc_pkg::DIV_W-1:0]         cfg_wr_data,
    output logic [mtc_pkg::WORD_W-1:0]        rd_word,
    output logic                              irq
);
    import mtc_pkg::*;

    logic              enable_reg, enable_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [TIME_W-1:0] cmp_reg, cmp_next;
    logic [DIV_W-1:0]  pre_reg, pre_next;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W:0]    pre_inc;

    assign pre_inc = {1'b0, pre_reg} + {{DIV_W{1'b0}}, 1'b1};

    always_comb
    begin
        enable_next = enable_reg;
        time_next   = time_reg;
        cmp_next    = cmp_reg;
        pre_next    = pre_reg;
        if (exec_en)
        begin
            case (item.func)
                FUNC_TICK:
                begin
                    if (enable_reg)
                    begin
                        // a divide of zero fires on every tick, as does one
                        if (pre_inc >= {1'b0, div_reg})
                        begin
                            pre_next  = '0;
                            time_next = time_reg + {{(TIME_W-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            pre_next = pre_inc[DIV_W-1:0];
                        end
                    end
                end
                FUNC_WRITE:
                begin
                    case (item.reg_index)
                        REG_CTRL:    enable_next = item.write_data[CTRL_ENABLE_BIT];
                        REG_TIME_LO: time_next[WORD_W-1:0] = item.write_data;
                        REG_TIME_HI: time_next[TIME_W-1:WORD_W] = item.write_data;
                        REG_CMP_LO:  cmp_next[WORD_W-1:0] = item.write_data;
                        REG_CMP_HI:  cmp_next[TIME_W-1:WORD_W] = item.write_data;
                        default:     ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rd_word = '0;
        if (item.func == FUNC_READ)
        begin
            case (item.reg_index)
                REG_CTRL:    rd_word[CTRL_ENABLE_BIT] = enable_reg;
                REG_TIME_LO: rd_word = time_reg[WORD_W-1:0];
                REG_TIME_HI: rd_word = time_reg[TIME_W-1:WORD_W];
                REG_CMP_LO:  rd_word = cmp_reg[WORD_W-1:0];
                REG_CMP_HI:  rd_word = cmp_reg[TIME_W-1:WORD_W];
                default:     rd_word = '0;
            endcase
        end
    end

    // compare on the stored state, which holds the post-item values
    assign irq = (time_reg >= cmp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            time_reg   <= '0;
            cmp_reg    <= CMP_RESET;
            pre_reg    <= '0;
            div_reg    <= TICK_DIVIDE_RESET;
        end
        else
        begin
            enable_reg <= enable_next;
            time_reg   <= time_next;
            cmp_reg    <= cmp_next;
            pre_reg    <= pre_next;
            if (cfg_wr_en)
            begin
                div_reg <= cfg_wr_data;
            end
        end
    end

`ifndef SYNTH
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_en |=> $stable(time_reg) && $stable(cmp_reg) && $stable(enable_reg)
            && $stable(pre_reg))
        else $error("timer state changed with no item executing");

    a_disabled_tick: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en && item.func == FUNC_TICK && !enable_reg
            |=> $stable(time_reg) && $stable(pre_reg))
        else $error("tick advanced a disabled timer");

    a_cmp_only_written: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en && item.func != FUNC_WRITE |=> $stable(cmp_reg) && $stable(enable_reg))
        else $error("compare or enable changed without a write item");
`endif

endmodule

[src/machine_timer_compare.sv]
// Machine timer with 64-bit time and compare behind a word-register bus.
// Items move through input, execute and result registers, a three-deep pipeline.
// Throughput: one item per cycle unless out_stall blocks the result register.
// All item state updates happen in the execute stage; cfg_wr_en sets the divide.
// Reset (rst_n, async, active low): timer disabled, time zero, compare all ones,
// prescaler zero, divide 50; pipeline empty.
module machine_timer_compare (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mtc_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mtc_pkg::out_item_t            out_item,
    input  logic                          cfg_wr_en,
    input  logic [mtc_pkg::DIV_W-1:0]     cfg_wr_data
);
    import mtc_pkg::*;

    logic              in_valid_reg;
    in_item_t          in_item_reg;
    logic              mid_valid_reg;
    logic [WORD_W-1:0] mid_rd_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic              adv_out;
    logic              adv_mid;
    logic              exec_en;
    logic [WORD_W-1:0] rd_word;
    logic              irq;

    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_mid  = !mid_valid_reg || adv_out;
    assign exec_en  = in_valid_reg && adv_mid;
    assign in_stall = in_valid_reg && !adv_mid;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    mtc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .exec_en     (exec_en),
        .item        (in_item_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rd_word     (rd_word),
        .irq         (irq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (adv_mid)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
        if (exec_en)
        begin
            mid_rd_reg <= rd_word;
        end
        // irq is sampled here, once the executed item's state has landed
        if (adv_out && mid_valid_reg)
        begin
            out_item_reg.read_data <= mid_rd_reg;
            out_item_reg.timer_irq <= irq;
        end
    end

`ifndef SYNTH
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en && in_item_reg.func != FUNC_READ |=> mid_rd_reg == '0)
        else $error("non-read item produced read data");

    a_ctrl_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en && in_item_reg.func == FUNC_READ && in_item_reg.reg_index == REG_CTRL
            |=> mid_rd_reg[WORD_W-1:1] == '0)
        else $error("ctrl read returned upper bits");

    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && !adv_out |=> mid_valid_reg && $stable(mid_rd_reg))
        else $error("execute stage item lost while result stalled");

    a_no_exec_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && out_valid_reg && out_stall |-> !exec_en)
        else $error("item executed while pipeline blocked");
`endif

endmodule
